// ===== rtl/eztq_pkg.sv =====
// ---------------------------------------------------------------------------
// eztq_pkg: shared types, widths and tables for the euler zyx to quaternion block
// Holds the fixed-point widths, the cordic gain start value and the arctangent steps.
// ---------------------------------------------------------------------------
package eztq_pkg;

    localparam int ANG_W             = 16;   // binary angle input width
    localparam int Q_W               = 16;   // Q1.15 output width
    localparam int CW                = 32;   // cordic datapath, Q.30
    localparam int PW                = 64;   // product width, Q.60
    localparam int HALF_SH           = 15;   // angle * 32768 gives the half angle
    localparam int PROD_SH           = 30;   // pair product back to Q.30
    localparam int OUT_SH            = 45;   // Q.60 down to Q.15
    localparam int ATAN_ENTRIES      = 24;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int S_TDATA_W         = 3 * ANG_W;
    localparam int M_TDATA_W         = 4 * Q_W;
    localparam int RND_W             = PW - OUT_SH;  // width after final shift

    localparam logic signed [CW-1:0] GAIN_START = 32'sd652032874;
    localparam logic signed [PW-1:0] RND_PROD   = 64'sd1 <<< (PROD_SH - 1);
    localparam logic signed [PW-1:0] RND_OUT    = 64'sd1 <<< (OUT_SH - 1);
    localparam logic signed [RND_W-1:0] SAT_MAX = 19'sd32767;
    localparam logic signed [RND_W-1:0] SAT_MIN = -19'sd32768;

    typedef logic signed [CW-1:0] t_cw;
    typedef logic signed [PW-1:0] t_pw;
    typedef logic signed [Q_W-1:0] t_q;

    // atan(2^-k) with 2^32 equal to 2*pi, truncated
    function automatic t_cw atan_step(input int unsigned k);
        t_cw v;
        begin
            unique case (k)
                0:  v = 32'sd536870912;
                1:  v = 32'sd316933406;
                2:  v = 32'sd167458907;
                3:  v = 32'sd85004756;
                4:  v = 32'sd42667331;
                5:  v = 32'sd21354465;
                6:  v = 32'sd10679838;
                7:  v = 32'sd5340245;
                8:  v = 32'sd2670163;
                9:  v = 32'sd1335087;
                10: v = 32'sd667544;
                11: v = 32'sd333772;
                12: v = 32'sd166886;
                13: v = 32'sd83443;
                14: v = 32'sd41721;
                15: v = 32'sd20860;
                16: v = 32'sd10430;
                17: v = 32'sd5215;
                18: v = 32'sd2607;
                19: v = 32'sd1303;
                20: v = 32'sd651;
                21: v = 32'sd325;
                22: v = 32'sd162;
                23: v = 32'sd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== rtl/euler_zyx_to_quaternion_top.sv =====
// ---------------------------------------------------------------------------
// euler_zyx_to_quaternion_top: roll/pitch/yaw to unit quaternion
// Three pipelined cordics give half-angle cos/sin, a product pipeline builds w, x, y, z.
// ---------------------------------------------------------------------------
//
//  channel   direction  width  fields (lowest bit up)
//  s side    in         48     roll_angle_in, pitch_angle_in, yaw_angle_in
//  m side    out        64     quat_w, quat_x, quat_y, quat_z
//
//  one transfer in per cycle while the skid stage is free, one result per transfer
//  registers on the path: cordic entry register, min(CORDIC_STAGES, 24) step
//    registers, five product/sum/round stages, one output register
//  while a result waits the pipeline keeps moving until the next result lands
//    in the skid stage; input is then refused until the skid drains, and the
//    drain cycle itself refuses input too
//  reset is synchronous, active low, and clears only the valid bits
//
module euler_zyx_to_quaternion_top #(
    parameter int CORDIC_STAGES = eztq_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // roll_angle_in [15:0], pitch_angle_in [31:16], yaw_angle_in [47:32]
    input  logic [eztq_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // master side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
    output logic [eztq_pkg::M_TDATA_W-1:0]     o_m_tdata
);
    import eztq_pkg::*;

    logic en;
    logic vld_r, vld_p, vld_y, vld_c;
    t_cw  cr, sr, cp, sp, cy, sy;
    t_q   qw, qx, qy, qz;

    // whole pipeline advances together while the skid stage is free
    assign o_s_tready = en;

    eztq_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_angle ($signed(i_s_tdata[ANG_W-1:0])),
        .o_vld   (vld_r),
        .o_cos   (cr),
        .o_sin   (sr)
    );

    eztq_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_angle ($signed(i_s_tdata[2*ANG_W-1:ANG_W])),
        .o_vld   (vld_p),
        .o_cos   (cp),
        .o_sin   (sp)
    );

    eztq_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_tvalid),
        .i_angle ($signed(i_s_tdata[3*ANG_W-1:2*ANG_W])),
        .o_vld   (vld_y),
        .o_cos   (cy),
        .o_sin   (sy)
    );

    // the three cordics run in lockstep, so their valid bits agree
    eztq_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (vld_r & vld_p & vld_y),
        .i_cr    (cr),
        .i_sr    (sr),
        .i_cp    (cp),
        .i_sp    (sp),
        .i_cy    (cy),
        .i_sy    (sy),
        .o_vld   (vld_c),
        .o_w     (qw),
        .o_x     (qx),
        .o_y     (qy),
        .o_z     (qz)
    );

    eztq_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (vld_c),
        .i_data     ({qz, qy, qx, qw}),
        .o_en       (en),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // lockstep cordics must never disagree on valid
    a_cordic_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vld_r == vld_p) && (vld_p == vld_y))
        else $error("cordic valid bits out of step");

    // a frozen pipeline keeps its last-stage valid
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(vld_c))
        else $error("pipeline moved while stalled");

    // input is refused only while a result is waiting at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> o_m_tvalid)
        else $error("input stalled with no pending result");

endmodule

// ===== rtl/eztq_cordic.sv =====
// ---------------------------------------------------------------------------
// eztq_cordic: pipelined rotation-mode cordic
// Gives cosine and sine (Q.30) of half of a binary angle, one register per step.
// ---------------------------------------------------------------------------
module eztq_cordic #(
    parameter int CORDIC_STAGES = eztq_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic signed [eztq_pkg::ANG_W-1:0] i_angle,
    output logic                              o_vld,
    output logic signed [eztq_pkg::CW-1:0]    o_cos,
    output logic signed [eztq_pkg::CW-1:0]    o_sin
);
    import eztq_pkg::*;

    localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    logic [NSTG:0] r_vld;
    t_cw           r_x [NSTG+1];
    t_cw           r_y [NSTG+1];
    t_cw           r_z [NSTG+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-1:0], i_vld};
        end
    end

    // entry register, then one micro-rotation per stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_START;
            r_y[0] <= '0;
            r_z[0] <= $signed({{(CW-ANG_W-HALF_SH){i_angle[ANG_W-1]}}, i_angle,
                               {HALF_SH{1'b0}}});
            for (int k = 0; k < NSTG; k++) begin
                if (!r_z[k][CW-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_step(k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_step(k);
                end
            end
        end
    end

    assign o_vld = r_vld[NSTG];
    assign o_cos = r_x[NSTG];
    assign o_sin = r_y[NSTG];

endmodule

// ===== rtl/eztq_combine.sv =====
// ---------------------------------------------------------------------------
// eztq_combine: half-angle product pipeline
// Forms the four quaternion components from the six half-angle cos/sin values.
// ---------------------------------------------------------------------------
module eztq_combine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic signed [eztq_pkg::CW-1:0]  i_cr,
    input  logic signed [eztq_pkg::CW-1:0]  i_sr,
    input  logic signed [eztq_pkg::CW-1:0]  i_cp,
    input  logic signed [eztq_pkg::CW-1:0]  i_sp,
    input  logic signed [eztq_pkg::CW-1:0]  i_cy,
    input  logic signed [eztq_pkg::CW-1:0]  i_sy,
    output logic                            o_vld,
    output logic signed [eztq_pkg::Q_W-1:0] o_w,
    output logic signed [eztq_pkg::Q_W-1:0] o_x,
    output logic signed [eztq_pkg::Q_W-1:0] o_y,
    output logic signed [eztq_pkg::Q_W-1:0] o_z
);
    import eztq_pkg::*;

    localparam int NPIPE = 5;

    logic [NPIPE-1:0] r_vld;

    // stage 1: pitch/yaw pair products
    t_pw r_m_cc, r_m_ss, r_m_sc, r_m_cs;
    t_cw r1_cr, r1_sr;
    // stage 2: pairs rounded to Q.30
    t_cw r_cpcy, r_spsy, r_spcy, r_cpsy;
    t_cw r2_cr, r2_sr;
    // stage 3: triple products, Q.60
    t_pw r_p_w0, r_p_w1, r_p_x0, r_p_x1, r_p_y0, r_p_y1, r_p_z0, r_p_z1;
    // stage 4: sums
    t_pw r_s_w, r_s_x, r_s_y, r_s_z;
    // stage 5: rounded and saturated
    t_q  r_w, r_x, r_y, r_z;

    t_pw n_cc, n_ss, n_sc, n_cs;

    assign n_cc = r_m_cc + RND_PROD;
    assign n_ss = r_m_ss + RND_PROD;
    assign n_sc = r_m_sc + RND_PROD;
    assign n_cs = r_m_cs + RND_PROD;

    function automatic t_q round_sat(input t_pw s);
        t_pw             t;
        logic signed [RND_W-1:0] v;
        t_q              q;
        begin
            t = s + RND_OUT;
            v = t[PW-1:OUT_SH];
            if (v > SAT_MAX) begin
                q = SAT_MAX[Q_W-1:0];
            end else if (v < SAT_MIN) begin
                q = SAT_MIN[Q_W-1:0];
            end else begin
                q = v[Q_W-1:0];
            end
            return q;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NPIPE-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_cc <= i_cp * i_cy;
            r_m_ss <= i_sp * i_sy;
            r_m_sc <= i_sp * i_cy;
            r_m_cs <= i_cp * i_sy;
            r1_cr  <= i_cr;
            r1_sr  <= i_sr;

            r_cpcy <= n_cc[CW+PROD_SH-1:PROD_SH];
            r_spsy <= n_ss[CW+PROD_SH-1:PROD_SH];
            r_spcy <= n_sc[CW+PROD_SH-1:PROD_SH];
            r_cpsy <= n_cs[CW+PROD_SH-1:PROD_SH];
            r2_cr  <= r1_cr;
            r2_sr  <= r1_sr;

            r_p_w0 <= r2_cr * r_cpcy;
            r_p_w1 <= r2_sr * r_spsy;
            r_p_x0 <= r2_sr * r_cpcy;
            r_p_x1 <= r2_cr * r_spsy;
            r_p_y0 <= r2_cr * r_spcy;
            r_p_y1 <= r2_sr * r_cpsy;
            r_p_z0 <= r2_cr * r_cpsy;
            r_p_z1 <= r2_sr * r_spcy;

            r_s_w  <= r_p_w0 + r_p_w1;
            r_s_x  <= r_p_x0 - r_p_x1;
            r_s_y  <= r_p_y0 + r_p_y1;
            r_s_z  <= r_p_z0 - r_p_z1;

            r_w    <= round_sat(r_s_w);
            r_x    <= round_sat(r_s_x);
            r_y    <= round_sat(r_s_y);
            r_z    <= round_sat(r_s_z);
        end
    end

    assign o_vld = r_vld[NPIPE-1];
    assign o_w   = r_w;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

// ===== rtl/eztq_skid.sv =====
// ---------------------------------------------------------------------------
// eztq_skid: output register with skid stage
// Holds results for the master side and advances the pipeline while the skid is empty.
// ---------------------------------------------------------------------------
module eztq_skid (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic [eztq_pkg::M_TDATA_W-1:0]      i_data,
    output logic                                o_en,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [eztq_pkg::M_TDATA_W-1:0]      o_m_tdata
);
    import eztq_pkg::*;

    logic                 r_ovld, r_svld;
    logic [M_TDATA_W-1:0] r_odata, r_sdata;
    logic                 take;

    assign o_en = !r_svld;
    assign take = o_en && i_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_svld <= 1'b0;
        end else if (!r_ovld || i_m_tready) begin
            if (r_svld) begin
                r_ovld <= 1'b1;
                r_svld <= 1'b0;
            end else begin
                r_ovld <= take;
            end
        end else if (take) begin
            r_svld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ovld || i_m_tready) begin
            r_odata <= r_svld ? r_sdata : i_data;
        end else if (take) begin
            r_sdata <= i_data;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = r_odata;

    // skid only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_svld |-> r_ovld)
        else $error("skid holds data with the output register empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_svld) |-> $past(r_ovld && !i_m_tready && i_vld))
        else $error("skid filled without a stalled output");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_svld && i_m_tready) |=> (r_ovld && !r_svld))
        else $error("skid did not drain into the output register");

endmodule

// ===== dv/eztq_checker.sv =====
// ---------------------------------------------------------------------------
// eztq_checker: scoreboard for the euler zyx to quaternion block
// Watches both stream channels. For each input transfer it works out the
// quaternion from its own cordic and product arithmetic. Each output transfer
// is compared, field by field and in order, against the oldest expected
// quaternion.
// ---------------------------------------------------------------------------
module eztq_checker #(
    parameter int STAGES = eztq_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // roll_angle_in [15:0], pitch_angle_in [31:16], yaw_angle_in [47:32]
    input  logic [eztq_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
    input  logic [eztq_pkg::M_TDATA_W-1:0] i_m_tdata,
    output int                             o_pending,
    output int                             o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import eztq_pkg::*;

    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        t_q z;
        t_q y;
        t_q x;
        t_q w;
    } quat_t;

    quat_t       quat_expected_q[$];
    quat_t       quat_want;
    quat_t       quat_got;
    int          fail_count   = 0;
    int unsigned result_index = 0;

    assign o_fail_count = fail_count;

    // atan(2^-k), 2^32 is a full turn, truncated
    function automatic longint arctan_step(input int k);
        case (k)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41721;
            15: return 20860;
            16: return 10430;
            17: return 5215;
            18: return 2607;
            19: return 1303;
            20: return 651;
            21: return 325;
            22: return 162;
            23: return 81;
            default: return 0;
        endcase
    endfunction

    // rotation-mode cordic on the half angle, Q.30 cos and sin
    function automatic void half_angle_cos_sin(input logic signed [ANG_W-1:0] ang,
                                               output longint cos_q30,
                                               output longint sin_q30);
        longint cx;
        longint sy;
        longint resid;
        longint dx;
        longint dy;
        cx    = longint'(GAIN_START);
        sy    = 0;
        resid = longint'(ang) * 32768;
        for (int k = 0; k < STAGES && k < ATAN_ENTRIES; k++) begin
            dx = sy >>> k;
            dy = cx >>> k;
            if (resid >= 0) begin
                cx    = cx - dx;
                sy    = sy + dy;
                resid = resid - arctan_step(k);
            end else begin
                cx    = cx + dx;
                sy    = sy - dy;
                resid = resid + arctan_step(k);
            end
        end
        cos_q30 = cx;
        sin_q30 = sy;
    endfunction

    function automatic longint round_pair(input longint a, input longint b);
        return (a * b + (longint'(1) <<< 29)) >>> 30;
    endfunction

    // Q.60 sum to Q1.15, ties upward, clamped
    function automatic t_q to_q15(input longint sum60);
        longint v;
        v = (sum60 + (longint'(1) <<< 44)) >>> 45;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return t_q'(v);
    endfunction

    function automatic quat_t predict_quaternion(input logic [S_TDATA_W-1:0] angles);
        longint cr, sr, cp, sp, cy, sy;
        longint cpcy, spsy, spcy, cpsy;
        quat_t  q;
        half_angle_cos_sin(angles[15:0],  cr, sr);
        half_angle_cos_sin(angles[31:16], cp, sp);
        half_angle_cos_sin(angles[47:32], cy, sy);
        cpcy = round_pair(cp, cy);
        spsy = round_pair(sp, sy);
        spcy = round_pair(sp, cy);
        cpsy = round_pair(cp, sy);
        q.w  = to_q15(cr * cpcy + sr * spsy);
        q.x  = to_q15(sr * cpcy - cr * spsy);
        q.y  = to_q15(cr * spcy + sr * cpsy);
        q.z  = to_q15(cr * cpsy - sr * spcy);
        return q;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input t_q got, input t_q want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      result_index, name, got, want));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                quat_expected_q.push_back(predict_quaternion(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (quat_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              result_index));
                end else begin
                    quat_want = quat_expected_q.pop_front();
                    quat_got  = quat_t'(i_m_tdata);
                    compare_field("w", quat_got.w, quat_want.w);
                    compare_field("x", quat_got.x, quat_want.x);
                    compare_field("y", quat_got.y, quat_want.y);
                    compare_field("z", quat_got.z, quat_want.z);
                end
                result_index++;
            end
            o_pending <= quat_expected_q.size();
        end
    end

endmodule

// ===== dv/tb_euler_zyx_to_quaternion_top.sv =====
// ---------------------------------------------------------------------------
// tb_euler_zyx_to_quaternion_top: testbench for the euler zyx to quaternion block
// Drives roll/pitch/yaw angle triples: first corner angles, then random ones,
// with random gaps on the input and random stalls on the output. The checker
// beside the block predicts and compares every quaternion.
// ---------------------------------------------------------------------------
module tb_euler_zyx_to_quaternion_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eztq_pkg::*;

    localparam int STAGES       = CORDIC_STAGES_DEF;
    localparam int RANDOM_ITEMS = 1550;
    // pipeline depth plus the skid stage, with some margin
    localparam int SETTLE_CYCLES = STAGES + 7 + 16;

    // all inputs known from time zero
    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    // roll_angle_in [15:0], pitch_angle_in [31:16], yaw_angle_in [47:32]
    logic [S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
    logic [M_TDATA_W-1:0] o_m_tdata;

    int pending;
    int fail_count;

    // when set, neither side idles
    bit calm = 1'b0;

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    euler_zyx_to_quaternion_top #(
        .CORDIC_STAGES (STAGES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    eztq_checker #(
        .STAGES (STAGES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // idle length: drawn from three random ranges, the shortest most often, the longest rarely
    function automatic int unsigned gap_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 6);
        else
            return $urandom_range(10, 40);
    endfunction

    // random angle: mostly full range, some near zero, some next to +/- pi
    function automatic logic [ANG_W-1:0] random_angle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return ANG_W'($urandom);
        else if (r < 85)
            return ANG_W'($urandom_range(0, 128)) - ANG_W'(64);
        else if (r < 93)
            return ANG_W'(16'h8000 + $urandom_range(0, 63));
        else
            return ANG_W'(16'h7fff - $urandom_range(0, 63));
    endfunction

    // output side: random stalls, held off while calm
    initial begin : sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (calm) begin
                stall_left = 0;
                i_m_tready <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = gap_length();
            end
        end
    end

    // one input transfer, after an optional random gap; tvalid stays high
    // across back-to-back transfers so it is never lowered and raised in one step
    task automatic send_angles(input logic [ANG_W-1:0] roll,
                               input logic [ANG_W-1:0] pitch,
                               input logic [ANG_W-1:0] yaw);
        int unsigned gap;
        gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_length();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {yaw, pitch, roll};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // hold the input until every expected quaternion has come out
    task automatic wait_all_answered();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero angle gives w of exactly one, which must clamp
        send_angles(16'sd0, 16'sd0, 16'sd0);
        // minus pi on each axis alone and on all three
        send_angles(16'h8000, 16'sd0, 16'sd0);
        send_angles(16'sd0, 16'h8000, 16'sd0);
        send_angles(16'sd0, 16'sd0, 16'h8000);
        send_angles(16'h8000, 16'h8000, 16'h8000);
        // largest positive angle
        send_angles(16'h7fff, 16'h7fff, 16'h7fff);
        send_angles(16'h7fff, 16'h8000, 16'sd0);
        // quarter turns, both signs
        send_angles(16'sd16384, 16'sd0, 16'sd0);
        send_angles(16'sd0, 16'sd16384, 16'sd0);
        send_angles(16'sd0, 16'sd0, 16'sd16384);
        send_angles(-16'sd16384, -16'sd16384, -16'sd16384);
        // smallest nonzero steps
        send_angles(16'sd1, -16'sd1, 16'sd1);
        send_angles(-16'sd1, 16'sd1, -16'sd1);
        // eighth turns and mixed signs
        send_angles(16'sd8192, 16'sd8192, 16'sd8192);
        send_angles(-16'sd8192, 16'sd8192, -16'sd8192);
        // alternating bit patterns, then assorted mixed angles
        send_angles(16'h5555, 16'haaaa, 16'h5555);
        send_angles(16'haaaa, 16'h5555, 16'haaaa);
        send_angles(16'hffff, 16'h0001, 16'h8001);
        send_angles(16'h8001, 16'h7ffe, 16'h4000);
        send_angles(16'hc000, 16'h2000, 16'he000);

        // drain once before the random part
        wait_all_answered();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // a stretch with no idling on either side
            calm = (n >= 800 && n < 1000);
            // pause until everything is out, a few times over the run
            if (n == 500 || n == 1100 || n == 1400)
                wait_all_answered();
            send_angles(random_angle(), random_angle(), random_angle());
        end
        calm = 1'b0;

        wait_all_answered();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("euler_zyx_to_quaternion_top verification clean");
        end else begin
            $display("euler_zyx_to_quaternion_top verification failed");
        end
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin : watchdog
        #8_000_000;
        $display("euler_zyx_to_quaternion_top verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/eztq_pkg.sv
rtl/eztq_cordic.sv
rtl/eztq_combine.sv
rtl/eztq_skid.sv
rtl/euler_zyx_to_quaternion_top.sv
dv/eztq_checker.sv
dv/tb_euler_zyx_to_quaternion_top.sv
